// ===== rtl/core/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg - shared types and constants of the catmull-rom curve sampler
// Field widths, operand widths of the shared multiply-add unit and the
// coefficient bundle passed from the coefficient logic to the sequencer.
// ----------------------------------------------------------------------------
package crs_pkg;

   // control point coordinate, unsigned 8.4
   localparam int COORD_W = 12;
   // curve sample, signed, 1/16 units
   localparam int SMP_W = 14;
   // offset quotient before the bias is removed, always positive
   localparam int Q_W = 13;
   // bias in samples added so that the scaled numerator stays positive
   localparam int OFFSET_Q = 2048;

   // operand and accumulator widths of the shared multiply-add unit
   localparam int OP_W = 30;
   localparam int ACC_W = 60;

   // per-segment polynomial coefficient widths
   localparam int A_W = 13;
   localparam int B_W = 17;
   localparam int C_W = 16;

   typedef struct packed {
      logic signed [A_W-1:0] a;   // p2 - p0
      logic signed [B_W-1:0] b;   // 2p0 - 5p1 + 4p2 - p3
      logic signed [C_W-1:0] c;   // -p0 + 3p1 - 3p2 + p3
   } coef_type;

endpackage

// ===== rtl/core/crs_coef.sv =====
// ----------------------------------------------------------------------------
// crs_coef - catmull-rom polynomial coefficients
// Forms the linear, quadratic and cubic coefficients of one coordinate of
// the current segment from its four control points.
// ----------------------------------------------------------------------------
module crs_coef
   import crs_pkg::*;
(
   input  logic [COORD_W-1:0] p0,
   input  logic [COORD_W-1:0] p1,
   input  logic [COORD_W-1:0] p2,
   input  logic [COORD_W-1:0] p3,
   output coef_type           coef
);

   localparam int EXT_W = 18;

   logic signed [EXT_W-1:0] e0;
   logic signed [EXT_W-1:0] e1;
   logic signed [EXT_W-1:0] e2;
   logic signed [EXT_W-1:0] e3;
   logic signed [EXT_W-1:0] sum_a;
   logic signed [EXT_W-1:0] sum_b;
   logic signed [EXT_W-1:0] sum_c;

   // zero extend the unsigned points
   assign e0 = signed'({{(EXT_W-COORD_W){1'b0}}, p0});
   assign e1 = signed'({{(EXT_W-COORD_W){1'b0}}, p1});
   assign e2 = signed'({{(EXT_W-COORD_W){1'b0}}, p2});
   assign e3 = signed'({{(EXT_W-COORD_W){1'b0}}, p3});

   // small constant multiples as shifts and adds
   assign sum_a = e2 - e0;
   assign sum_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
   assign sum_c = (e1 <<< 1) + e1 + e3 - e0 - (e2 <<< 1) - e2;

   assign coef.a = sum_a[A_W-1:0];
   assign coef.b = sum_b[B_W-1:0];
   assign coef.c = sum_c[C_W-1:0];

endmodule

// ===== rtl/core/crs_mac.sv =====
// ----------------------------------------------------------------------------
// crs_mac - shared multiply-add unit
// Signed x * y + z, used for every coefficient scaling, every horner step
// and the reciprocal multiply that replaces the final division.
// ----------------------------------------------------------------------------
module crs_mac
   import crs_pkg::*;
(
   input  logic signed [OP_W-1:0]  x_op,
   input  logic signed [OP_W-1:0]  y_op,
   input  logic signed [ACC_W-1:0] z_op,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [2*OP_W-1:0] prod;

   // one multiplier, one adder
   assign prod = x_op * y_op;
   assign acc  = ACC_W'(prod) + z_op;

endmodule

// ===== rtl/core/catmull_rom_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler - uniform catmull-rom curve sampler
// Takes control points one request at a time and returns the rounded
// samples of each finished segment, the closing segment and the end point.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_point_x, req_point_y, req_last_point
//   rsp      out  rsp_valid/rsp_stall   rsp_sample_x, rsp_sample_y, rsp_last_sample
//
// For each segment the sequencer runs six coefficient scalings, then per
// sample eight multiply-adds on the one shared multiplier and one result
// handshake; a point that closes no segment only updates the window. A final
// point adds its closing segment and the end-point result. Synchronous reset
// clears the window and count; req_stall is high from acceptance until the
// window is updated after the last result, rsp_stall waits.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler
   import crs_pkg::*;
#(
   parameter int SAMPLES_PER_SEGMENT = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COORD_W-1:0]       req_point_x,
   input  logic [COORD_W-1:0]       req_point_y,
   input  logic                     req_last_point,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SMP_W-1:0]  rsp_sample_x,
   output logic signed [SMP_W-1:0]  rsp_sample_y,
   output logic                     rsp_last_sample
);

   // derived constants
   localparam int SMP_CNT_W = (SAMPLES_PER_SEGMENT > 1) ? $clog2(SAMPLES_PER_SEGMENT) : 1;
   localparam int S_SQ      = SAMPLES_PER_SEGMENT * SAMPLES_PER_SEGMENT;
   localparam int S_CB      = S_SQ * SAMPLES_PER_SEGMENT;
   localparam int DIV_C     = 2 * S_CB;
   localparam int DIV_B     = $clog2(DIV_C);
   localparam int NUM_W     = Q_W + DIV_B;
   localparam int SHIFT     = NUM_W + DIV_B;
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(DIV_C) - 64'd1) / 64'(DIV_C);
   localparam int ROUND_K   = S_CB + OFFSET_Q * DIV_C;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   // operation kinds within a coordinate, low two bits of the step
   localparam logic [1:0] K_LIN  = 2'd0;
   localparam logic [1:0] K_QUAD = 2'd1;
   localparam logic [1:0] K_CONS = 2'd2;
   localparam logic [1:0] K_DIV  = 2'd3;

   localparam logic [2:0] STEP_SETUP_LAST = 3'd6;
   localparam logic [2:0] STEP_EVAL_LAST  = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           step_ff, step_in;
   logic [SMP_CNT_W-1:0] smp_ff, smp_in;
   logic                 seg_ff, seg_in;
   logic                 close_ff, close_in;
   logic                 last_ff, last_in;
   logic [1:0]           count_ff, count_in;
   logic [COORD_W-1:0]   win_x_ff [3];
   logic [COORD_W-1:0]   win_x_in [3];
   logic [COORD_W-1:0]   win_y_ff [3];
   logic [COORD_W-1:0]   win_y_in [3];

   logic [COORD_W-1:0]     new_x_ff;
   logic [COORD_W-1:0]     new_y_ff;
   logic signed [OP_W-1:0] t_ff;
   logic signed [OP_W-1:0] bs_ff [2];
   logic signed [OP_W-1:0] as_ff [2];
   logic signed [OP_W-1:0] c0_ff [2];
   logic [SMP_W-1:0]       out_x_ff;
   logic [SMP_W-1:0]       out_y_ff;

   logic                   req_take;
   logic                   csel;
   logic [1:0]             kind;
   logic [COORD_W-1:0]     w0, w1, w2, np;
   logic [COORD_W-1:0]     p0, p1, p2, p3;
   coef_type               coef;
   logic signed [OP_W-1:0]  x_op;
   logic signed [OP_W-1:0]  y_op;
   logic signed [ACC_W-1:0] z_op;
   logic signed [ACC_W-1:0] acc;
   logic [SMP_W-1:0]        smp_val;
   logic signed [OP_W-1:0]  smp_op;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csel      = step_ff[2];
   assign kind      = step_ff[1:0];

   // control points of the current segment and coordinate
   assign w0 = csel ? win_y_ff[0] : win_x_ff[0];
   assign w1 = csel ? win_y_ff[1] : win_x_ff[1];
   assign w2 = csel ? win_y_ff[2] : win_x_ff[2];
   assign np = csel ? new_y_ff : new_x_ff;

   always_comb begin
      if (!seg_ff) begin
         p0 = (count_ff == 2'd2) ? w1 : w0;
         p1 = w1;
         p2 = w2;
         p3 = np;
      end else begin
         p0 = (count_ff >= 2'd2) ? w1 : w2;
         p1 = w2;
         p2 = np;
         p3 = np;
      end
   end

   crs_coef u_coef (
      .p0   (p0),
      .p1   (p1),
      .p2   (p2),
      .p3   (p3),
      .coef (coef)
   );

   // operand selection for the shared unit
   assign smp_op = signed'({{(OP_W-SMP_CNT_W){1'b0}}, smp_ff});

   always_comb begin
      x_op = '0;
      y_op = '0;
      z_op = '0;
      if (state_ff == ST_SETUP) begin
         unique case (kind)
            K_LIN: begin
               x_op = {{(OP_W-B_W){coef.b[B_W-1]}}, coef.b};
               y_op = OP_W'(SAMPLES_PER_SEGMENT);
            end
            K_QUAD: begin
               x_op = {{(OP_W-A_W){coef.a[A_W-1]}}, coef.a};
               y_op = OP_W'(S_SQ);
            end
            K_CONS: begin
               x_op = {{(OP_W-COORD_W){1'b0}}, p1};
               y_op = OP_W'(DIV_C);
               z_op = ACC_W'(ROUND_K);
            end
            default: begin
               x_op = '0;
            end
         endcase
      end else if (state_ff == ST_EVAL) begin
         unique case (kind)
            K_LIN: begin
               x_op = {{(OP_W-C_W){coef.c[C_W-1]}}, coef.c};
               y_op = smp_op;
               z_op = {{(ACC_W-OP_W){bs_ff[csel][OP_W-1]}}, bs_ff[csel]};
            end
            K_QUAD: begin
               x_op = t_ff;
               y_op = smp_op;
               z_op = {{(ACC_W-OP_W){as_ff[csel][OP_W-1]}}, as_ff[csel]};
            end
            K_CONS: begin
               x_op = t_ff;
               y_op = smp_op;
               z_op = {{(ACC_W-OP_W){c0_ff[csel][OP_W-1]}}, c0_ff[csel]};
            end
            K_DIV: begin
               x_op = t_ff;
               y_op = RECIP[OP_W-1:0];
            end
         endcase
      end
   end

   crs_mac u_mac (
      .x_op (x_op),
      .y_op (y_op),
      .z_op (z_op),
      .acc  (acc)
   );

   // quotient of the reciprocal multiply, bias removed
   assign smp_val = {1'b0, acc[SHIFT +: Q_W]} - SMP_W'(OFFSET_Q);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      smp_in   = smp_ff;
      seg_in   = seg_ff;
      close_in = close_ff;
      last_in  = last_ff;
      count_in = count_ff;
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_last_point;
               close_in = req_last_point && (count_ff != 2'd0);
               step_in  = '0;
               smp_in   = '0;
               priority if (count_ff >= 2'd2) begin
                  seg_in   = 1'b0;
                  state_in = ST_SETUP;
               end else if (req_last_point && (count_ff != 2'd0)) begin
                  seg_in   = 1'b1;
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SETUP: begin
            priority if (step_ff == STEP_SETUP_LAST) begin
               step_in  = '0;
               state_in = ST_EVAL;
            end else if (kind == K_CONS) begin
               step_in = step_ff + 3'd2;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_EVAL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_EVAL_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               step_in = '0;
               if (smp_ff == SMP_CNT_W'(SAMPLES_PER_SEGMENT - 1)) begin
                  smp_in = '0;
                  priority if (!seg_ff && close_ff) begin
                     seg_in   = 1'b1;
                     state_in = ST_SETUP;
                  end else if (close_ff) begin
                     state_in = ST_END;
                  end else begin
                     state_in = ST_FIN;
                  end
               end else begin
                  smp_in   = smp_ff + SMP_CNT_W'(1);
                  state_in = ST_EVAL;
               end
            end
         end
         ST_END: begin
            if (!rsp_stall) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // window update, or a fresh curve after the final point
            if (last_ff) begin
               win_x_in = '{default: '0};
               win_y_in = '{default: '0};
               count_in = 2'd0;
            end else begin
               win_x_in = '{win_x_ff[1], win_x_ff[2], new_x_ff};
               win_y_in = '{win_y_ff[1], win_y_ff[2], new_y_ff};
               count_in = (count_ff == 2'd3) ? 2'd3 : count_ff + 2'd1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         smp_ff   <= '0;
         seg_ff   <= 1'b0;
         close_ff <= 1'b0;
         last_ff  <= 1'b0;
         count_ff <= 2'd0;
         win_x_ff <= '{default: '0};
         win_y_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         smp_ff   <= smp_in;
         seg_ff   <= seg_in;
         close_ff <= close_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         win_x_ff <= win_x_in;
         win_y_ff <= win_y_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         new_x_ff <= req_point_x;
         new_y_ff <= req_point_y;
      end
      if (state_ff == ST_SETUP) begin
         unique case (kind)
            K_LIN:   bs_ff[csel] <= acc[OP_W-1:0];
            K_QUAD:  as_ff[csel] <= acc[OP_W-1:0];
            K_CONS:  c0_ff[csel] <= acc[OP_W-1:0];
            default: t_ff        <= t_ff;
         endcase
      end
      if (state_ff == ST_EVAL) begin
         if (kind == K_DIV) begin
            if (csel) begin
               out_y_ff <= smp_val;
            end else begin
               out_x_ff <= smp_val;
            end
         end else begin
            t_ff <= acc[OP_W-1:0];
         end
      end
   end

   // result port
   assign rsp_valid       = (state_ff == ST_OUT) || (state_ff == ST_END);
   assign rsp_last_sample = (state_ff == ST_END);
   assign rsp_sample_x    = (state_ff == ST_END) ? {2'b00, new_x_ff} : out_x_ff;
   assign rsp_sample_y    = (state_ff == ST_END) ? {2'b00, new_y_ff} : out_y_ff;

`ifndef SYNTHESIS
   // no result is offered while a new request can be taken
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result offered while idle");

   // an accepted request closes the input until its results are done
   a_take_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port open after acceptance");

   // the end-point result is the last one of its request
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_sample |=> !rsp_valid)
      else $error("result after the end point");

   // sample index stays inside the segment
   a_smp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> smp_ff <= SMP_CNT_W'(SAMPLES_PER_SEGMENT - 1))
      else $error("sample index out of range");
`endif

endmodule

// ===== dv/catmull_rom_curve_sampler_tb.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler_tb - self-checking bench for the curve sampler
// Feeds curves of control points, directed corner cases first and then
// random curves of random length, and predicts every sample, the closing
// segment and the end point in a scoreboard. Each result taken from the
// block is compared field by field with the oldest prediction. The sender
// runs in bursts and the receiver stalls on shifting patterns, with one
// long hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler_tb
   import crs_pkg::*;
();

   localparam int SEG_SAMPLES = 16;
   localparam int SEG_CUBE = SEG_SAMPLES * SEG_SAMPLES * SEG_SAMPLES;
   localparam logic [COORD_W-1:0] COORD_MAX = '1;
   localparam int DIRECTED_POINTS = 18;
   localparam int RANDOM_POINTS = 82;
   localparam int HOLD_AFTER = 40;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 400;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [SMP_W-1:0] x;
      logic signed [SMP_W-1:0] y;
      logic                    is_last;
   } sample_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // predicts the samples of each curve from the accepted control points
   class spline_scoreboard_type;
      sample_type samples_due[$];
      logic [COORD_W-1:0] win_x[3];
      logic [COORD_W-1:0] win_y[3];
      int unsigned seen;
      int unsigned checked;
      int unsigned failures;

      function new();
         clear_curve();
         checked = 0;
         failures = 0;
      endfunction

      function void clear_curve();
         for (int i = 0; i < 3; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
         end
         seen = 0;
      endfunction

      // one coordinate of the cubic, rounded to 1/16 with ties up
      function logic signed [SMP_W-1:0] spline_coord(longint p0, longint p1,
                                                      longint p2, longint p3,
                                                      longint s);
         longint a;
         longint b;
         longint c;
         longint num;
         longint q;
         a = p2 - p0;
         b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         c = -p0 + 3 * p1 - 3 * p2 + p3;
         num = 2 * p1 * SEG_CUBE + a * s * SEG_SAMPLES * SEG_SAMPLES
               + b * s * s * SEG_SAMPLES + c * s * s * s + SEG_CUBE;
         q = num / (2 * SEG_CUBE);
         if ((num % (2 * SEG_CUBE)) != 0 && num < 0)
            q = q - 1;
         return q[SMP_W-1:0];
      endfunction

      function void push_segment(longint x0, longint x1, longint x2, longint x3,
                                 longint y0, longint y1, longint y2, longint y3);
         sample_type smp;
         for (int s = 0; s < SEG_SAMPLES; s++) begin
            smp.x = spline_coord(x0, x1, x2, x3, s);
            smp.y = spline_coord(y0, y1, y2, y3, s);
            smp.is_last = 1'b0;
            samples_due.push_back(smp);
         end
      endfunction

      // accepted control point: queue the samples it releases
      function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                               logic is_last);
         int unsigned cnt;
         sample_type smp;
         cnt = seen;
         // inner segment, p0 doubled on the first segment
         if (cnt >= 2)
            push_segment((cnt == 2) ? win_x[1] : win_x[0], win_x[1], win_x[2], px,
                         (cnt == 2) ? win_y[1] : win_y[0], win_y[1], win_y[2], py);
         // closing segment with the end point doubled, then the end point
         if (is_last && cnt >= 1) begin
            push_segment((cnt >= 2) ? win_x[1] : win_x[2], win_x[2], px, px,
                         (cnt >= 2) ? win_y[1] : win_y[2], win_y[2], py, py);
            smp.x = {{(SMP_W-COORD_W){1'b0}}, px};
            smp.y = {{(SMP_W-COORD_W){1'b0}}, py};
            smp.is_last = 1'b1;
            samples_due.push_back(smp);
         end
         // window update, new curve after a final point
         if (is_last) begin
            clear_curve();
         end else begin
            win_x[0] = win_x[1];
            win_y[0] = win_y[1];
            win_x[1] = win_x[2];
            win_y[1] = win_y[2];
            win_x[2] = px;
            win_y[2] = py;
            if (cnt < 3)
               seen = cnt + 1;
         end
      endfunction

      // accepted sample: compare against the oldest prediction
      function void check_sample(logic signed [SMP_W-1:0] sx,
                                 logic signed [SMP_W-1:0] sy, logic is_last);
         sample_type want;
         checked++;
         if (samples_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("sample %0d unexpected: x=%0d y=%0d last=%0b",
                        checked, sx, sy, is_last);
         end else begin
            want = samples_due.pop_front();
            if (want.x !== sx || want.y !== sy || want.is_last !== is_last) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("sample %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           checked, want.x, want.y, want.is_last, sx, sy, is_last);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_W-1:0] req_point_x = '0;
   logic [COORD_W-1:0] req_point_y = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SMP_W-1:0] rsp_sample_x;
   logic signed [SMP_W-1:0] rsp_sample_y;
   logic rsp_last_sample;

   logic holding = 1'b0;
   int unsigned points_sent = 0;
   int unsigned burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned mode_left = 0;
   int unsigned stall_phase = 0;
   spline_scoreboard_type curve_check = new();

   catmull_rom_curve_sampler #(
      .SAMPLES_PER_SEGMENT(SEG_SAMPLES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_x(rsp_sample_x),
      .rsp_sample_y(rsp_sample_y),
      .rsp_last_sample(rsp_last_sample)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // random coordinate, weighted towards the extremes
   function automatic logic [COORD_W-1:0] pick_coord();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      else if (roll == 1)
         return COORD_MAX;
      else
         return COORD_W'($urandom_range(0, COORD_MAX));
   endfunction

   // offer one point, wait for the request to be taken, then pace the burst
   task automatic send_point(input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py, input logic is_last);
      int unsigned gap;
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_last_point <= is_last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      curve_check.note_point(px, py, is_last);
      points_sent++;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 300)
                                           : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(1, 6);
      end else begin
         burst_left--;
      end
   endtask

   // stimulus
   initial begin
      int unsigned len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone points give nothing
      send_point(12'd100, 12'd200, 1'b1);
      send_point(COORD_MAX, 12'd0, 1'b1);
      // two-point curve across the full range
      send_point(12'd0, 12'd0, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b1);
      // three points with maximum overshoot
      send_point(COORD_MAX, 12'd0, 1'b0);
      send_point(12'd0, COORD_MAX, 1'b0);
      send_point(COORD_MAX, 12'd0, 1'b1);
      // long zig-zag curve, count saturates
      for (int i = 0; i < 7; i++)
         send_point((i % 2) ? COORD_MAX : 12'd0, (i % 2) ? 12'd0 : COORD_MAX, i == 6);
      // mid-range curve with alternating bit patterns
      send_point(12'haaa, 12'h555, 1'b0);
      send_point(12'h555, 12'haaa, 1'b0);
      send_point(12'h800, 12'h7ff, 1'b0);
      send_point(12'h7ff, 12'h800, 1'b1);

      // random curves of random length
      while (points_sent < DIRECTED_POINTS + RANDOM_POINTS) begin
         len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
         for (int i = 0; i < len; i++)
            send_point(pick_coord(), pick_coord(), i == len - 1);
      end

      // drain
      req_valid <= 1'b0;
      while (curve_check.samples_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (curve_check.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // long receiver hold-off once the run is under way
   initial begin
      wait (points_sent >= HOLD_AFTER);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   // receiver: take samples and stall on a shifting pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            curve_check.check_sample(rsp_sample_x, rsp_sample_y, rsp_last_sample);
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 120);
            stall_phase = $urandom_range(2, 5);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= holding;
            STALL_LIGHT: rsp_stall <= holding || ($urandom_range(0, 9) < 3);
            STALL_HEAVY: rsp_stall <= holding || ($urandom_range(0, 9) < 7);
            default: rsp_stall <= holding || ((mode_left % stall_phase) == 0);
         endcase
      end
   end

   // watchdog
   initial begin
      #(12 * 400000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/crs_pkg.sv
rtl/core/crs_coef.sv
rtl/core/crs_mac.sv
rtl/core/catmull_rom_curve_sampler.sv
dv/catmull_rom_curve_sampler_tb.sv
